FILE: hdl/audio_clock_rate_monitor_assert.svh
// Assertion macros for the audio clock rate monitor.
// Used by the top level only; no dependencies.
`ifndef AUDIO_CLOCK_RATE_MONITOR_ASSERT_SVH
`define AUDIO_CLOCK_RATE_MONITOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ACRM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("acrm: implication check failed");
// Next-cycle implication.
`define ACRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("acrm: next-cycle check failed");
`else
`define ACRM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ACRM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/acrm_pkg.sv
// Shared types and constants of the audio clock rate monitor.
// No dependencies; used by every module of the block.
`default_nettype none

package acrm_pkg;

	typedef struct packed {
		logic [31:0] frame_sample;
		logic [15:0] interval_us;
	} acrm_in_t;

	typedef struct packed {
		logic clock_valid;
		logic recovery_ready;
		logic clock_stopped;
	} acrm_out_t;

	// Register indexes of the configuration port
	localparam logic [1:0] ACRM_REG_WINDOW_US   = 2'd0;
	localparam logic [1:0] ACRM_REG_TOLERANCE   = 2'd1;
	localparam logic [1:0] ACRM_REG_STOPPED_US  = 2'd2;
	localparam logic [1:0] ACRM_REG_FRAMES_PMS  = 2'd3;

	localparam logic [15:0] ACRM_WINDOW_US_RST  = 16'd16000;
	localparam logic [9:0]  ACRM_TOLERANCE_RST  = 10'd10;
	localparam logic [15:0] ACRM_STOPPED_US_RST = 16'd4000;
	localparam logic [7:0]  ACRM_FRAMES_PMS_RST = 8'd48;

	// Flag update carried from the window stage to the decision stage
	localparam logic [1:0] ACRM_OP_KEEP  = 2'd0;
	localparam logic [1:0] ACRM_OP_CLEAR = 2'd1;
	localparam logic [1:0] ACRM_OP_STOP  = 2'd2;
	localparam logic [1:0] ACRM_OP_CHECK = 2'd3;

	// Rounded divide by 1000: floor((p + 500) * RECIP / 2^35) for p + 500 < 2^25
	localparam logic [24:0] ACRM_ROUND_HALF  = 25'd500;
	localparam logic [25:0] ACRM_RECIP       = 26'd34359739;
	localparam int          ACRM_RECIP_SHIFT = 35;

	typedef struct packed {
		logic [1:0]  op;
		logic        stopped;
		logic [31:0] frames;
		logic [24:0] product;
	} acrm_win_t;

	typedef struct packed {
		logic [1:0]  op;
		logic        stopped;
		logic [31:0] frames;
		logic [15:0] expected;
	} acrm_exp_t;

endpackage

`default_nettype wire

FILE: hdl/audio_clock_rate_monitor.sv
// Audio clock rate monitor. Takes one sample transaction per cycle while not stalled
// and returns one result per sample, which passes in order through the input register,
// window stage (frame delta, window and stop timer, rate product), reciprocal divide
// stage and decision/result register.
// Each of the two middle stages holds one multiplier.
// The stages move independently, so new samples are taken while a result waits.
// The user writes configuration via cfg_we/cfg_index/cfg_data only while idle; the block itself does not enforce this.
// Depends on acrm_pkg, acrm_front, acrm_scale, acrm_judge and the assertion header.
`default_nettype none

`include "audio_clock_rate_monitor_assert.svh"

module audio_clock_rate_monitor (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire acrm_pkg::acrm_in_t in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output acrm_pkg::acrm_out_t     out_data,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	logic [15:0] window_us_q;
	logic [9:0]  tolerance_q;
	logic [15:0] stopped_us_q;
	logic [7:0]  frames_pms_q;

	logic v1_q;
	logic v2_q;
	logic v3_q;
	logic vo_q;
	logic r1;
	logic r2;
	logic r3;
	logic ro;
	logic [2:0] occ;
	logic in_take;
	logic out_take;

	acrm_pkg::acrm_in_t  item_s1;
	acrm_pkg::acrm_win_t win;
	acrm_pkg::acrm_exp_t expv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_us_q  <= acrm_pkg::ACRM_WINDOW_US_RST;
			tolerance_q  <= acrm_pkg::ACRM_TOLERANCE_RST;
			stopped_us_q <= acrm_pkg::ACRM_STOPPED_US_RST;
			frames_pms_q <= acrm_pkg::ACRM_FRAMES_PMS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				acrm_pkg::ACRM_REG_WINDOW_US:  window_us_q  <= cfg_data;
				acrm_pkg::ACRM_REG_TOLERANCE:  tolerance_q  <= cfg_data[9:0];
				acrm_pkg::ACRM_REG_STOPPED_US: stopped_us_q <= cfg_data;
				acrm_pkg::ACRM_REG_FRAMES_PMS: frames_pms_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// a stage may load when it is empty or its content moves on
	assign ro       = !vo_q || !out_stall;
	assign r3       = !v3_q || ro;
	assign r2       = !v2_q || r3;
	assign r1       = !v1_q || r2;
	assign in_stall = !r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (r1) begin
				v1_q <= in_valid;
			end
			if (r2) begin
				v2_q <= v1_q;
			end
			if (r3) begin
				v3_q <= v2_q;
			end
			if (ro) begin
				vo_q <= v3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && in_valid) begin
			item_s1 <= in_data;
		end
	end

	acrm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.xfer          (v1_q && r2),
		.item          (item_s1),
		.window_us     (window_us_q),
		.stopped_us    (stopped_us_q),
		.frames_per_ms (frames_pms_q),
		.win           (win)
	);

	acrm_scale u_scale (
		.clk   (clk),
		.xfer  (v2_q && r3),
		.win   (win),
		.exp_o (expv)
	);

	acrm_judge u_judge (
		.clk             (clk),
		.arst_n          (arst_n),
		.xfer            (v3_q && ro),
		.exp_i           (expv),
		.frame_tolerance (tolerance_q),
		.result          (out_data)
	);

	assign out_valid = vo_q;

	assign occ      = {2'd0, v1_q} + {2'd0, v2_q} + {2'd0, v3_q} + {2'd0, vo_q};
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;

	// an empty pipeline never pushes back
	`ACRM_ASSERT_IMPLY(a_empty_ready, clk, arst_n, occ == 3'd0, !in_stall)
	// a transaction taken with none leaving adds exactly one to the occupancy
	`ACRM_ASSERT_NEXT(a_occ_up, clk, arst_n, in_take && !out_take, occ == $past(occ) + 3'd1)
	// a transaction leaving with none taken removes exactly one
	`ACRM_ASSERT_NEXT(a_occ_down, clk, arst_n, !in_take && out_take, occ == $past(occ) - 3'd1)

endmodule

`default_nettype wire

FILE: hdl/acrm_front.sv
// Window stage: frame delta, window and stop timer update, rate product.
// Depends on acrm_pkg.
`default_nettype none

module acrm_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              xfer,
	input  wire acrm_pkg::acrm_in_t item,
	input  wire logic [15:0]       window_us,
	input  wire logic [15:0]       stopped_us,
	input  wire logic [7:0]        frames_per_ms,
	output acrm_pkg::acrm_win_t    win
);

	logic [31:0] last_q;
	logic        started_q;
	logic [31:0] frames_q;
	logic [16:0] time_q;
	logic [15:0] stop_q;

	logic [31:0] last_n;
	logic        started_n;
	logic [31:0] frames_n;
	logic [16:0] time_n;
	logic [15:0] stop_n;

	logic [31:0] delta;
	logic [31:0] frames_sum;
	logic [16:0] time_sum;
	logic [15:0] stop_room;
	logic [24:0] product;
	acrm_pkg::acrm_win_t win_n;
	acrm_pkg::acrm_win_t win_s2;

	assign delta      = item.frame_sample - last_q;
	assign frames_sum = frames_q + delta;
	assign time_sum   = time_q + {1'b0, item.interval_us};
	assign stop_room  = stopped_us - stop_q;
	assign product    = {8'd0, time_sum} * {17'd0, frames_per_ms};

	always_comb begin
		last_n        = last_q;
		started_n     = started_q;
		frames_n      = frames_q;
		time_n        = time_q;
		stop_n        = stop_q;
		win_n.op      = acrm_pkg::ACRM_OP_KEEP;
		win_n.stopped = (stop_q >= stopped_us);
		win_n.frames  = frames_sum;
		win_n.product = product;
		if (item.interval_us != 16'd0) begin
			last_n = item.frame_sample;
			if (!started_q) begin
				started_n     = 1'b1;
				frames_n      = 32'd0;
				time_n        = 17'd0;
				stop_n        = 16'd0;
				win_n.op      = acrm_pkg::ACRM_OP_CLEAR;
				win_n.stopped = (stopped_us == 16'd0);
			end else if (delta == 32'd0) begin
				frames_n = 32'd0;
				time_n   = 17'd0;
				// saturate the stop timer at the limit
				if (stop_q >= stopped_us || item.interval_us >= stop_room) begin
					stop_n = stopped_us;
				end else begin
					stop_n = stop_q + item.interval_us;
				end
				win_n.stopped = (stop_n >= stopped_us);
				if (stop_n >= stopped_us) begin
					win_n.op = acrm_pkg::ACRM_OP_STOP;
				end
			end else begin
				stop_n        = 16'd0;
				win_n.stopped = (stopped_us == 16'd0);
				if (time_sum >= {1'b0, window_us}) begin
					win_n.op = acrm_pkg::ACRM_OP_CHECK;
					frames_n = 32'd0;
					time_n   = 17'd0;
				end else begin
					frames_n = frames_sum;
					time_n   = time_sum;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= 32'd0;
			started_q <= 1'b0;
			frames_q  <= 32'd0;
			time_q    <= 17'd0;
			stop_q    <= 16'd0;
		end else if (xfer) begin
			last_q    <= last_n;
			started_q <= started_n;
			frames_q  <= frames_n;
			time_q    <= time_n;
			stop_q    <= stop_n;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			win_s2 <= win_n;
		end
	end

	assign win = win_s2;

endmodule

`default_nettype wire

FILE: hdl/acrm_scale.sv
// Scale stage: rounded divide of the rate product by 1000 via reciprocal.
// Depends on acrm_pkg.
`default_nettype none

module acrm_scale (
	input  wire logic               clk,
	input  wire logic               xfer,
	input  wire acrm_pkg::acrm_win_t win,
	output acrm_pkg::acrm_exp_t     exp_o
);

	logic [24:0] num;
	logic [50:0] scaled;
	acrm_pkg::acrm_exp_t exp_n;
	acrm_pkg::acrm_exp_t exp_s3;

	assign num    = win.product + acrm_pkg::ACRM_ROUND_HALF;
	assign scaled = {26'd0, num} * {25'd0, acrm_pkg::ACRM_RECIP};

	always_comb begin
		exp_n.op       = win.op;
		exp_n.stopped  = win.stopped;
		exp_n.frames   = win.frames;
		exp_n.expected = scaled[acrm_pkg::ACRM_RECIP_SHIFT +: 16];
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			exp_s3 <= exp_n;
		end
	end

	assign exp_o = exp_s3;

endmodule

`default_nettype wire

FILE: hdl/acrm_judge.sv
// Decision stage: tolerance check, valid/recovery flags, result register.
// Depends on acrm_pkg.
`default_nettype none

module acrm_judge (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               xfer,
	input  wire acrm_pkg::acrm_exp_t exp_i,
	input  wire logic [9:0]         frame_tolerance,
	output acrm_pkg::acrm_out_t     result
);

	logic valid_q;
	logic ever_q;
	logic recov_q;
	logic valid_n;
	logic ever_n;
	logic recov_n;

	logic [31:0] lo;
	logic [31:0] hi;
	logic        in_range;
	acrm_pkg::acrm_out_t result_q;

	// bounds wrap modulo 2^32
	assign lo       = {16'd0, exp_i.expected} - {22'd0, frame_tolerance};
	assign hi       = {16'd0, exp_i.expected} + {22'd0, frame_tolerance};
	assign in_range = (exp_i.frames >= lo) && (exp_i.frames <= hi);

	always_comb begin
		valid_n = valid_q;
		ever_n  = ever_q;
		recov_n = recov_q;
		case (exp_i.op)
			acrm_pkg::ACRM_OP_KEEP: begin
			end
			acrm_pkg::ACRM_OP_CLEAR: begin
				valid_n = 1'b0;
				ever_n  = 1'b0;
				recov_n = 1'b0;
			end
			acrm_pkg::ACRM_OP_STOP: begin
				valid_n = 1'b0;
				recov_n = recov_q | ever_q;
			end
			acrm_pkg::ACRM_OP_CHECK: begin
				valid_n = in_range;
				ever_n  = ever_q | in_range;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ever_q  <= 1'b0;
			recov_q <= 1'b0;
		end else if (xfer) begin
			valid_q <= valid_n;
			ever_q  <= ever_n;
			recov_q <= recov_n;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			result_q.clock_valid    <= valid_n;
			result_q.recovery_ready <= valid_n & recov_n;
			result_q.clock_stopped  <= exp_i.stopped;
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking bench for audio_clock_rate_monitor: a table of directed samples and phases of
// random sample streams, each result checked against its typed value or a cycle-free model of the window logic.
// Depends on acrm_pkg and the audio_clock_rate_monitor RTL.
`default_nettype none

module tb;

	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		logic                is_cfg;
		logic [1:0]          idx;
		logic [15:0]         val;
		acrm_pkg::acrm_in_t  smp;
		logic                typed;
		acrm_pkg::acrm_out_t want;
	} script_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	acrm_pkg::acrm_in_t  in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	acrm_pkg::acrm_out_t out_data;
	logic                cfg_we = 1'b0;
	logic [1:0]          cfg_index = '0;
	logic [15:0]         cfg_data = '0;

	// register copies
	logic [15:0] cfg_window = acrm_pkg::ACRM_WINDOW_US_RST;
	logic [9:0]  cfg_tol = acrm_pkg::ACRM_TOLERANCE_RST;
	logic [15:0] cfg_stop = acrm_pkg::ACRM_STOPPED_US_RST;
	logic [7:0]  cfg_fpm = acrm_pkg::ACRM_FRAMES_PMS_RST;

	// monitor state
	logic [31:0] mon_last = '0;
	logic        mon_started = 1'b0;
	logic [31:0] mon_frames = '0;
	logic [16:0] mon_time = '0;
	logic [15:0] mon_stop = '0;
	logic        mon_valid = 1'b0;
	logic        mon_ever = 1'b0;
	logic        mon_recov = 1'b0;

	acrm_pkg::acrm_out_t flag_queue[$];
	script_row_t         script[$];
	int                  errors = 0;
	int                  quiet_cycles = 0;
	bit                  tx_idle_on = 1'b1;
	bit                  rx_idle_on = 1'b1;
	bit                  rx_hold_req = 1'b0;

	audio_clock_rate_monitor uut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.in_data,
		.out_valid,
		.out_stall,
		.out_data,
		.cfg_we,
		.cfg_index,
		.cfg_data
	);

	always #2 clk = ~clk;

	function automatic acrm_pkg::acrm_out_t monitor_step(input acrm_pkg::acrm_in_t smp);
		logic [31:0]         delta;
		logic [31:0]         expected;
		logic [31:0]         lo;
		logic [31:0]         hi;
		acrm_pkg::acrm_out_t r;
		if (smp.interval_us != 16'd0) begin
			if (!mon_started) begin
				mon_frames = '0;
				mon_time = '0;
				mon_stop = '0;
				mon_valid = 1'b0;
				mon_ever = 1'b0;
				mon_recov = 1'b0;
				mon_last = smp.frame_sample;
				mon_started = 1'b1;
			end else begin
				delta = smp.frame_sample - mon_last;
				mon_last = smp.frame_sample;
				if (delta == 32'd0) begin
					mon_frames = '0;
					mon_time = '0;
					// saturate the stop timer at the limit
					if (mon_stop >= cfg_stop || smp.interval_us >= cfg_stop - mon_stop)
						mon_stop = cfg_stop;
					else
						mon_stop = mon_stop + smp.interval_us;
					if (mon_stop >= cfg_stop) begin
						mon_recov = mon_recov | mon_ever;
						mon_valid = 1'b0;
					end
				end else begin
					mon_stop = '0;
					mon_frames = mon_frames + delta;
					mon_time = mon_time + 17'(smp.interval_us);
					if (32'(mon_time) >= 32'(cfg_window)) begin
						expected = (32'(mon_time) * 32'(cfg_fpm) + 32'd500) / 32'd1000;
						// bounds wrap modulo 2^32
						lo = expected - 32'(cfg_tol);
						hi = expected + 32'(cfg_tol);
						mon_valid = (mon_frames >= lo) && (mon_frames <= hi);
						mon_ever = mon_ever | mon_valid;
						mon_frames = '0;
						mon_time = '0;
					end
				end
			end
		end
		r.clock_valid = mon_valid;
		r.recovery_ready = mon_valid && mon_recov;
		r.clock_stopped = (mon_stop >= cfg_stop);
		return r;
	endfunction

	function automatic script_row_t sample_row(input logic [31:0] frame, input logic [15:0] dt,
			input logic typed, input acrm_pkg::acrm_out_t want);
		script_row_t row;
		row.is_cfg = 1'b0;
		row.idx = '0;
		row.val = '0;
		row.smp.frame_sample = frame;
		row.smp.interval_us = dt;
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	function automatic script_row_t reg_row(input logic [1:0] idx, input logic [15:0] val);
		script_row_t row;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = val;
		row.smp = '0;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	task automatic send_sample(input acrm_pkg::acrm_in_t smp, input logic typed,
			input acrm_pkg::acrm_out_t want);
		int                  gap;
		acrm_pkg::acrm_out_t pred;
		gap = tx_idle_on ? int'($urandom_range(0, 6)) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= smp;
		do @(posedge clk); while (in_stall);
		pred = monitor_step(smp);
		flag_queue.push_back(typed ? want : pred);
	endtask

	// Drop valid and wait until every pending result is back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (flag_queue.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			acrm_pkg::ACRM_REG_WINDOW_US: cfg_window = val;
			acrm_pkg::ACRM_REG_TOLERANCE: cfg_tol = val[9:0];
			acrm_pkg::ACRM_REG_STOPPED_US: cfg_stop = val;
			acrm_pkg::ACRM_REG_FRAMES_PMS: cfg_fpm = val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$display("%0t %s: expected %b, actual %b", $time, name, want, got);
			errors++;
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin : rx_side
		int n;
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = rx_idle_on ? int'($urandom_range(0, 6)) : 0;
				if (n != 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : result_check
		acrm_pkg::acrm_out_t want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("audio_clock_rate_monitor: mismatch");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (flag_queue.size() == 0) begin
					$display("%0t unexpected result: expected none, actual %b", $time, out_data);
					errors++;
				end else begin
					want = flag_queue.pop_front();
					check_field("clock_valid", want.clock_valid, out_data.clock_valid);
					check_field("recovery_ready", want.recovery_ready, out_data.recovery_ready);
					check_field("clock_stopped", want.clock_stopped, out_data.clock_stopped);
				end
			end
		end
	end

	initial begin : stimulus
		acrm_pkg::acrm_in_t  smp;
		acrm_pkg::acrm_out_t none;
		int                  nominal;
		int                  dt_max;
		int                  stop_left;
		int                  r;
		int                  jit_delta;
		logic [31:0]         delta;
		none = '0;
		stop_left = 0;

		// directed samples; typed results follow the window logic by hand
		script.push_back(sample_row(32'hFFFF_FFF0, 16'd0, 1'b1, 3'b000));
		script.push_back(sample_row(32'hFFFF_FFF0, 16'd1, 1'b1, 3'b000));
		// counter wraps, exactly nominal count
		script.push_back(sample_row(32'h0000_02F0, 16'd16000, 1'b1, 3'b100));
		script.push_back(sample_row(32'h1234_5678, 16'd0, 1'b1, 3'b100));
		script.push_back(sample_row(32'h0000_02F0, 16'd65535, 1'b1, 3'b001));
		script.push_back(sample_row(32'h0000_05F0, 16'd16000, 1'b1, 3'b110));
		// tolerance edges around 768 frames
		script.push_back(sample_row(32'h0000_08FA, 16'd16000, 1'b1, 3'b110));
		script.push_back(sample_row(32'h0000_0C05, 16'd16000, 1'b1, 3'b000));
		script.push_back(sample_row(32'h0000_0EFB, 16'd16000, 1'b1, 3'b110));
		script.push_back(sample_row(32'h0000_11F0, 16'd16000, 1'b1, 3'b000));
		script.push_back(sample_row(32'h0000_1254, 16'd100, 1'b0, none));
		script.push_back(sample_row(32'hFFFF_FFFF, 16'hFFFF, 1'b0, none));
		script.push_back(sample_row(32'h0000_0000, 16'hFFFF, 1'b0, none));
		script.push_back(sample_row(32'h5555_5555, 16'hAAAA, 1'b0, none));
		script.push_back(sample_row(32'hAAAA_AAAA, 16'h5555, 1'b0, none));
		// small expected count: lower bound wraps and the window fails
		script.push_back(reg_row(acrm_pkg::ACRM_REG_WINDOW_US, 16'd1));
		script.push_back(reg_row(acrm_pkg::ACRM_REG_TOLERANCE, 16'd1023));
		script.push_back(reg_row(acrm_pkg::ACRM_REG_FRAMES_PMS, 16'd1));
		script.push_back(sample_row(32'hAAAA_AAAF, 16'd1, 1'b1, 3'b000));
		// zero stop limit
		script.push_back(reg_row(acrm_pkg::ACRM_REG_STOPPED_US, 16'd0));
		script.push_back(sample_row(32'hAAAA_AAAF, 16'd0, 1'b1, 3'b001));
		script.push_back(sample_row(32'hAAAA_AAAF, 16'd5, 1'b1, 3'b001));
		// zero window, then zero rate
		script.push_back(reg_row(acrm_pkg::ACRM_REG_WINDOW_US, 16'd0));
		script.push_back(reg_row(acrm_pkg::ACRM_REG_TOLERANCE, 16'd0));
		script.push_back(reg_row(acrm_pkg::ACRM_REG_FRAMES_PMS, 16'd255));
		script.push_back(reg_row(acrm_pkg::ACRM_REG_STOPPED_US, 16'd65535));
		script.push_back(sample_row(32'hAAAA_AAB0, 16'd4, 1'b0, none));
		script.push_back(reg_row(acrm_pkg::ACRM_REG_FRAMES_PMS, 16'd0));
		script.push_back(sample_row(32'hAAAA_AAB1, 16'd4, 1'b0, none));
		// lower the stop limit below a running timer
		script.push_back(reg_row(acrm_pkg::ACRM_REG_FRAMES_PMS, 16'd48));
		script.push_back(reg_row(acrm_pkg::ACRM_REG_STOPPED_US, 16'd60000));
		script.push_back(sample_row(32'hAAAA_AAB1, 16'd30000, 1'b0, none));
		script.push_back(reg_row(acrm_pkg::ACRM_REG_STOPPED_US, 16'd100));
		script.push_back(sample_row(32'hAAAA_AAB1, 16'd0, 1'b0, none));
		script.push_back(sample_row(32'hAAAA_AAB1, 16'd1, 1'b0, none));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				drain_results();
				write_reg(script[i].idx, script[i].val);
			end else begin
				send_sample(script[i].smp, script[i].typed, script[i].want);
			end
		end

		for (int p = 0; p < 8; p++) begin
			drain_results();
			write_reg(acrm_pkg::ACRM_REG_WINDOW_US, (p == 1) ? 16'd65535 :
				(p == 2) ? 16'd1 : 16'($urandom_range(200, 8000)));
			write_reg(acrm_pkg::ACRM_REG_TOLERANCE, (p == 2) ? 16'd0 :
				(p == 4) ? 16'd1023 : 16'($urandom_range(0, 40)));
			write_reg(acrm_pkg::ACRM_REG_STOPPED_US, (p == 3) ? 16'd1 :
				(p == 5) ? 16'd65535 : 16'($urandom_range(200, 6000)));
			write_reg(acrm_pkg::ACRM_REG_FRAMES_PMS, (p == 1) ? 16'd255 :
				(p == 6) ? 16'd1 : 16'($urandom_range(8, 200)));
			tx_idle_on = (p % 4 != 3);
			rx_idle_on = (p != 7);
			// back-pressure the output while the sender streams
			if (p == 3)
				rx_hold_req = 1'b1;
			dt_max = int'(cfg_window) / 3 + 1;
			stop_left = 0;
			for (int k = 0; k < 138; k++) begin
				r = int'($urandom_range(0, 99));
				if (stop_left > 0 || r < 4) begin
					// no new frames
					if (stop_left == 0)
						stop_left = int'($urandom_range(1, 6));
					stop_left--;
					smp.frame_sample = mon_last;
					smp.interval_us = 16'($urandom_range(1, int'(cfg_stop) / 2 + 1));
				end else if (r < 8) begin
					smp.frame_sample = $urandom;
					smp.interval_us = 16'd0;
				end else if (r < 14) begin
					smp.frame_sample = $urandom;
					smp.interval_us = 16'($urandom_range(0, 65535));
				end else begin
					smp.interval_us = 16'($urandom_range(1, dt_max));
					nominal = (int'(smp.interval_us) * int'(cfg_fpm) + 500) / 1000;
					jit_delta = nominal + int'($urandom_range(0, 4)) - 2;
					if (jit_delta < 1)
						jit_delta = 1;
					delta = 32'(jit_delta);
					smp.frame_sample = mon_last + delta;
				end
				send_sample(smp, 1'b0, none);
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("audio_clock_rate_monitor: match");
		else
			$display("audio_clock_rate_monitor: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
